// ===== rtl/core/modbus_ascii_reply_receiver_macros.svh =====
// Assertion helpers for the reply receiver.
`ifndef MODBUS_ASCII_REPLY_RECEIVER_MACROS_SVH
`define MODBUS_ASCII_REPLY_RECEIVER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MARR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MARR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/marr_pkg.sv =====
`default_nettype none

package marr_pkg;

  localparam logic [7:0] CHAR_COLON  = 8'd58;
  localparam logic [7:0] HEX_SPLIT   = 8'd58;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_ALPHA = 8'd55;

  // Frame character positions (0 = hunting for colon).
  localparam logic [3:0] POS_HUNT    = 4'd0;
  localparam logic [3:0] POS_FIRST   = 4'd1;
  localparam logic [3:0] POS_ADDR_LO = 4'd2;
  localparam logic [3:0] POS_FUNC_LO = 4'd4;
  localparam logic [3:0] POS_DATA_HI = 4'd8;
  localparam logic [3:0] POS_DATA_LO = 4'd10;
  localparam logic [3:0] POS_LRC_LO  = 4'd12;
  localparam logic [3:0] POS_LAST    = 4'd14;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_LRC_BAD = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  addr;
    logic [7:0]  func;
    logic [15:0] data;
  } res_t;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = (c < HEX_SPLIT) ? (c - ASCII_ZERO) : (c - ASCII_ALPHA);
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/marr_if.sv =====
`default_nettype none

interface marr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;

  modport source (output valid, output rx_char, input ready);
  modport sink   (input valid, input rx_char, output ready);
endinterface

interface marr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [7:0]  slave_address;
  logic [7:0]  function_code;
  logic [15:0] data_word;

  modport source (output valid, output frame_status, output slave_address,
                  output function_code, output data_word, input ready);
  modport sink   (input valid, input frame_status, input slave_address,
                  input function_code, input data_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/modbus_ascii_reply_receiver.sv =====
// Data path: an accepted char word waits in the input reg until the parser steps; a frame
//   or timeout result waits in the result reg for out_ch (one input reg, one result reg).
// Throughput: one char word per cycle unless out_ch stalls, limited by the single-pass parser step.
// Reset (rst_n low, synchronous): hunting for colon, hunt count zero, both
//   stages empty, hunt_limit zero (wait forever).
`default_nettype none

`include "modbus_ascii_reply_receiver_macros.svh"

module modbus_ascii_reply_receiver (
  input  wire logic   clk,
  input  wire logic   rst_n,
  marr_in_if.sink     in_ch,
  marr_out_if.source  out_ch,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  // Config register: the user must write it only while idle; the block does not enforce this.
  logic [7:0] hunt_limit_r;

  // Input stage.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;

  // Result stage.
  logic           out_valid_r, out_valid_nxt;
  marr_pkg::res_t out_res_r;

  logic           advance;   // parser consumes the staged char this cycle
  logic           res_valid;
  marr_pkg::res_t res;

  // Parser steps when a char is staged and the result register can take a word (empty or draining).
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_limit_r <= 8'd0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        hunt_limit_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload regs, no reset.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.rx_char;
    end
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  marr_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .rx_char    (s1_char_r),
    .hunt_limit (hunt_limit_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_status  = out_res_r.status;
  assign out_ch.slave_address = out_res_r.addr;
  assign out_ch.function_code = out_res_r.func;
  assign out_ch.data_word     = out_res_r.data;

  // Timeout words never carry frame fields.
  `MARR_ASSERT_NOW(a_timeout_zero, clk, rst_n, out_valid_r && (out_res_r.status == marr_pkg::ST_TIMEOUT), (out_res_r.addr == 8'd0) && (out_res_r.func == 8'd0) && (out_res_r.data == 16'd0), "timeout result with nonzero fields")
  // Staged char must hold while the result register is blocked.
  `MARR_ASSERT_NOW(a_stall_blocks_in, clk, rst_n, s1_valid_r && out_valid_r && !out_ch.ready, !in_ch.ready && !advance, "input taken while result stalled")
  // A result word that is waiting is not overwritten.
  `MARR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ch.ready, out_valid_r && $stable(out_res_r), "stalled result changed")

endmodule

`default_nettype wire

// ===== rtl/core/marr_frame.sv =====
`default_nettype none

// Frame parser: one character per step, hunt counter, LRC accumulate.
module marr_frame (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       rx_char,
  input  wire logic [7:0]       hunt_limit,
  output logic                  res_valid,
  output marr_pkg::res_t        res
);

  logic [3:0]  pos_r,   pos_nxt;
  logic [7:0]  hunt_r,  hunt_nxt;
  logic [7:0]  lrc_r,   lrc_nxt;
  logic [3:0]  hinib_r, hinib_nxt;
  logic [7:0]  addr_r,  addr_nxt;
  logic [7:0]  func_r,  func_nxt;
  logic [15:0] data_r,  data_nxt;
  logic        lrc_ok_r, lrc_ok_nxt;

  logic [3:0]  nib;
  logic [7:0]  byte_val;
  logic [7:0]  sum;
  logic [7:0]  hunt_inc;
  logic        hunting;

  assign nib      = marr_pkg::hex_nibble(rx_char);
  assign byte_val = {hinib_r, nib};
  assign sum      = lrc_r + byte_val;
  assign hunt_inc = hunt_r + 8'd1;
  assign hunting  = (pos_r == marr_pkg::POS_HUNT) || (pos_r > marr_pkg::POS_LAST);

  always_comb begin
    pos_nxt    = pos_r;
    hunt_nxt   = hunt_r;
    lrc_nxt    = lrc_r;
    hinib_nxt  = hinib_r;
    addr_nxt   = addr_r;
    func_nxt   = func_r;
    data_nxt   = data_r;
    lrc_ok_nxt = lrc_ok_r;
    res_valid  = 1'b0;
    res.status = marr_pkg::ST_GOOD;
    res.addr   = addr_r;
    res.func   = func_r;
    res.data   = data_r;
    if (step) begin
      if (hunting) begin
        if (rx_char == marr_pkg::CHAR_COLON) begin
          pos_nxt    = marr_pkg::POS_FIRST;
          hunt_nxt   = 8'd0;
          lrc_nxt    = 8'd0;
          hinib_nxt  = 4'd0;
          lrc_ok_nxt = 1'b0;
        end else begin
          pos_nxt = marr_pkg::POS_HUNT;
          if (hunt_limit != 8'd0) begin
            if (hunt_inc >= hunt_limit) begin
              hunt_nxt   = 8'd0;
              res_valid  = 1'b1;
              res.status = marr_pkg::ST_TIMEOUT;
              res.addr   = 8'd0;
              res.func   = 8'd0;
              res.data   = 16'd0;
            end else begin
              hunt_nxt = hunt_inc;
            end
          end
        end
      end else begin
        if (pos_r <= marr_pkg::POS_LRC_LO) begin
          if (pos_r[0]) begin
            hinib_nxt = nib;
          end else if (pos_r == marr_pkg::POS_LRC_LO) begin
            lrc_ok_nxt = (sum == 8'd0);
          end else begin
            lrc_nxt = sum;
            case (pos_r)
              marr_pkg::POS_ADDR_LO: addr_nxt = byte_val;
              marr_pkg::POS_FUNC_LO: func_nxt = byte_val;
              marr_pkg::POS_DATA_HI: data_nxt = {byte_val, data_r[7:0]};
              marr_pkg::POS_DATA_LO: data_nxt = {data_r[15:8], byte_val};
              default: ;
            endcase
          end
        end
        if (pos_r == marr_pkg::POS_LAST) begin
          pos_nxt    = marr_pkg::POS_HUNT;
          hunt_nxt   = 8'd0;
          res_valid  = 1'b1;
          res.status = lrc_ok_r ? marr_pkg::ST_GOOD : marr_pkg::ST_LRC_BAD;
        end else begin
          pos_nxt = pos_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= marr_pkg::POS_HUNT;
      hunt_r <= 8'd0;
    end else begin
      pos_r  <= pos_nxt;
      hunt_r <= hunt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lrc_r    <= lrc_nxt;
    hinib_r  <= hinib_nxt;
    addr_r   <= addr_nxt;
    func_r   <= func_nxt;
    data_r   <= data_nxt;
    lrc_ok_r <= lrc_ok_nxt;
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the Modbus ASCII reply receiver.
module testbench;

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam int QUIET_LIMIT = 3000;   // cycles with no word moving on either side
  localparam int CHAR_BUDGET = 1050;   // input words to send, roughly
  localparam int SETTLE_CYCLES = 4;    // one input reg + one result reg, plus margin

  localparam marr_pkg::res_t TIMED_OUT = '{status: marr_pkg::ST_TIMEOUT, addr: 8'h00,
                                           func: 8'h00, data: 16'h0000};
  localparam marr_pkg::res_t ALL_ONES  = '{status: marr_pkg::ST_GOOD, addr: 8'hFF,
                                           func: 8'hFF, data: 16'hFFFF};

  // Directed rows: write the limit, send a char the predictor judges, send a char
  // known to give nothing, or send a char whose reply is spelled out.
  typedef enum logic [1:0] {ROW_CFG, ROW_CHAR, ROW_QUIET, ROW_RESULT} row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    logic [7:0]     value;
    marr_pkg::res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  marr_in_if  in_ch();
  marr_out_if out_ch();

  modbus_ascii_reply_receiver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame parser mirror. Same state as the block, advanced once per accepted
  // char word. Position, hunt count and limit match the block right after reset.
  // ---------------------------------------------------------------------------
  logic [7:0]  limit_q  = 8'd0;   // hunt_limit as last written
  logic [3:0]  fr_pos   = marr_pkg::POS_HUNT;
  logic [7:0]  hunt_cnt = 8'd0;
  logic [7:0]  lrc_acc  = 8'd0;
  logic [3:0]  nib_hi   = 4'd0;
  logic [7:0]  addr_q   = 8'd0;
  logic [7:0]  func_q   = 8'd0;
  logic [15:0] data_q   = 16'd0;
  logic        lrc_ok   = 1'b0;

  marr_pkg::res_t replies_due[$];   // replies owed by the block, oldest first

  int faults = 0;
  int chars_sent = 0;
  int n_good = 0;
  int n_lrc_bad = 0;
  int n_timeout = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit jitter_on = 1'b0;

  // Returns 1 when this char completes a reply; the reply goes to r.
  function automatic bit parse_char(input logic [7:0] c, output marr_pkg::res_t r);
    logic [7:0] v;
    logic [3:0] nib;
    logic [7:0] pair;
    r = '0;
    if (fr_pos == marr_pkg::POS_HUNT || fr_pos > marr_pkg::POS_LAST) begin
      // Colon always opens a frame, even as the last char the limit allows.
      if (c == marr_pkg::CHAR_COLON) begin
        fr_pos = marr_pkg::POS_FIRST;
        hunt_cnt = 8'd0;
        lrc_acc = 8'd0;
        nib_hi = 4'd0;
        lrc_ok = 1'b0;
        return 1'b0;
      end
      fr_pos = marr_pkg::POS_HUNT;
      if (limit_q != 8'd0) begin
        hunt_cnt = hunt_cnt + 8'd1;
        // >= so that a limit lowered mid-hunt trips on the next char
        if (hunt_cnt >= limit_q) begin
          hunt_cnt = 8'd0;
          r.status = marr_pkg::ST_TIMEOUT;
          return 1'b1;
        end
      end
      return 1'b0;
    end
    if (fr_pos <= marr_pkg::POS_LRC_LO) begin
      // any char decodes, hex or not; only the low nibble survives
      v = (c < marr_pkg::HEX_SPLIT) ? c - marr_pkg::ASCII_ZERO : c - marr_pkg::ASCII_ALPHA;
      nib = v[3:0];
      if (fr_pos[0]) begin
        nib_hi = nib;
      end else begin
        pair = {nib_hi, nib};
        if (fr_pos == marr_pkg::POS_LRC_LO) begin
          lrc_ok = (8'(lrc_acc + pair) == 8'h00);
        end else begin
          lrc_acc = lrc_acc + pair;
          case (fr_pos)
            marr_pkg::POS_ADDR_LO: addr_q = pair;
            marr_pkg::POS_FUNC_LO: func_q = pair;
            marr_pkg::POS_DATA_HI: data_q[15:8] = pair;
            marr_pkg::POS_DATA_LO: data_q[7:0] = pair;
            default: ;
          endcase
        end
      end
    end
    // CR and LF slots are taken blind; the reply leaves on the LF slot
    if (fr_pos == marr_pkg::POS_LAST) begin
      fr_pos = marr_pkg::POS_HUNT;
      hunt_cnt = 8'd0;
      r.status = lrc_ok ? marr_pkg::ST_GOOD : marr_pkg::ST_LRC_BAD;
      r.addr = addr_q;
      r.func = func_q;
      r.data = data_q;
      return 1'b1;
    end
    fr_pos = fr_pos + 4'd1;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Valid stays up between back-to-back words and only drops for
  // an idle burst or when the sender stops.
  // ---------------------------------------------------------------------------
  task automatic put_char(input logic [7:0] c);
    if (jitter_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_char <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic feed_char(input logic [7:0] c);
    marr_pkg::res_t r;
    put_char(c);
    if (parse_char(c, r)) replies_due.push_back(r);
  endtask

  // Limit changes only with the block drained: all replies in, then the
  // pipeline given time to swallow chars that produce nothing.
  task automatic write_limit(input logic [7:0] v);
    in_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    limit_q = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Canonical uppercase most of the time, lowercase letters too (they decode
  // to the same nibble), and junk in sloppy frames.
  function automatic logic [7:0] digit_char(input logic [3:0] n, input bit sloppy);
    if (sloppy && $urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    if (n >= 4'd10) begin
      if ($urandom_range(0, 2) == 0) return 8'd87 + 8'(n);
      return marr_pkg::ASCII_ALPHA + 8'(n);
    end
    return marr_pkg::ASCII_ZERO + 8'(n);
  endfunction

  // Whole reply frame: addr, func, byte count, data hi/lo, LRC, CR, LF.
  task automatic send_frame();
    logic [7:0] fld[6];
    logic [7:0] total;
    bit sloppy;
    fld[0] = pick_byte();
    fld[1] = pick_byte();
    fld[2] = ($urandom_range(0, 3) == 0) ? pick_byte() : 8'h02;
    fld[3] = pick_byte();
    fld[4] = pick_byte();
    total = fld[0] + fld[1] + fld[2] + fld[3] + fld[4];
    fld[5] = -total;
    if ($urandom_range(0, 4) == 0) fld[5] = fld[5] ^ 8'($urandom_range(1, 255));
    sloppy = ($urandom_range(0, 5) == 0);
    feed_char(marr_pkg::CHAR_COLON);
    for (int i = 0; i < 6; i++) begin
      feed_char(digit_char(fld[i][7:4], sloppy));
      feed_char(digit_char(fld[i][3:0], sloppy));
    end
    feed_char((sloppy && $urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : CHAR_CR);
    feed_char((sloppy && $urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : CHAR_LF);
  endtask

  task automatic send_noise(input int n, input bit colon_ok);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(0, 255));
      while (!colon_ok && c == marr_pkg::CHAR_COLON) c = 8'($urandom_range(0, 255));
      feed_char(c);
    end
  endtask

  // Frame cut short; the next colon lands inside it as a plain char.
  task automatic send_broken();
    feed_char(marr_pkg::CHAR_COLON);
    repeat ($urandom_range(1, 13)) feed_char(digit_char(4'($urandom_range(0, 15)), 1'b0));
  endtask

  function automatic stim_row_t row(input row_kind_t k, input logic [7:0] v,
                                    input marr_pkg::res_t r = '0);
    stim_row_t s;
    s.kind = k;
    s.value = v;
    s.res = r;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready stalls in bursts while jitter is on.
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (jitter_on && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      faults++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    marr_pkg::res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (replies_due.size() == 0) begin
        faults++;
        $display("%0t: unexpected reply, expected none, got status %0d %02h %02h %04h",
                 $time, out_ch.frame_status, out_ch.slave_address,
                 out_ch.function_code, out_ch.data_word);
      end else begin
        want = replies_due.pop_front();
        check_field("frame_status", 16'(want.status), 16'(out_ch.frame_status));
        check_field("slave_address", 16'(want.addr), 16'(out_ch.slave_address));
        check_field("function_code", 16'(want.func), 16'(out_ch.function_code));
        check_field("data_word", want.data, out_ch.data_word);
        case (want.status)
          marr_pkg::ST_GOOD:    n_good++;
          marr_pkg::ST_LRC_BAD: n_lrc_bad++;
          default:              n_timeout++;
        endcase
      end
    end
  end

  // Watchdog: any stretch with no word moving on either side is a hang.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d replies outstanding",
               $time, QUIET_LIMIT, replies_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t plan[$];
    string body;
    marr_pkg::res_t scratch;
    logic [7:0] lim;
    int phase;
    int stop_at;
    int pick;

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.rx_char <= 8'h00;
    cfg_we <= 1'b0;
    cfg_wdata <= 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    plan.push_back(row(ROW_QUIET, 8'h55));           // limit 0 out of reset: wait forever
    plan.push_back(row(ROW_CFG, 8'd3));
    plan.push_back(row(ROW_QUIET, 8'h00));
    plan.push_back(row(ROW_QUIET, 8'hFF));
    plan.push_back(row(ROW_RESULT, "Z", TIMED_OUT)); // third stray char trips the limit
    plan.push_back(row(ROW_QUIET, "A"));
    plan.push_back(row(ROW_QUIET, "B"));
    plan.push_back(row(ROW_QUIET, marr_pkg::CHAR_COLON)); // colon as last allowed char opens frame
    body = "FFFF02FFFF02";                           // all-ones frame, LRC 02
    for (int i = 0; i < body.len(); i++) plan.push_back(row(ROW_CHAR, body[i]));
    plan.push_back(row(ROW_CHAR, CHAR_CR));
    plan.push_back(row(ROW_RESULT, CHAR_LF, ALL_ONES));
    plan.push_back(row(ROW_QUIET, "x"));
    plan.push_back(row(ROW_QUIET, "y"));
    plan.push_back(row(ROW_CFG, 8'd1));              // limit dropped below the count
    plan.push_back(row(ROW_RESULT, 8'h80, TIMED_OUT));

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG:  write_limit(plan[i].value);
        ROW_CHAR: feed_char(plan[i].value);
        default: begin
          put_char(plan[i].value);
          void'(parse_char(plan[i].value, scratch));
          if (plan[i].kind == ROW_RESULT) replies_due.push_back(plan[i].res);
        end
      endcase
    end

    // Random part: phases with one limit each; mostly clean frames with
    // random content, the rest stray chars and cut-off frames.
    phase = 0;
    while (chars_sent < CHAR_BUDGET) begin
      case (phase)
        0: lim = 8'd0;
        1: lim = 8'd1;
        2: lim = 8'd255;
        default: lim = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 4))
                                                   : 8'($urandom_range(0, 255));
      endcase
      write_limit(lim);
      jitter_on = (phase % 3 != 2) && (chars_sent < CHAR_BUDGET - 150);
      if (lim == 8'd255) send_noise(270, 1'b0);   // long enough to reach the top limit
      stop_at = chars_sent + 120;
      while (chars_sent < stop_at && chars_sent < CHAR_BUDGET) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) send_frame();
        else if (pick == 7) send_noise($urandom_range(1, 30), 1'b1);
        else if (pick == 8) send_broken();
        else send_noise($urandom_range(1, 6), 1'b0);
      end
      phase++;
    end
    jitter_on = 1'b0;

    in_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES + 2) @(posedge clk);

    $display("Sent %0d chars over %0d limit settings.", chars_sent, phase + 2);
    $display("Replies seen: %0d good, %0d LRC mismatch, %0d hunt timeouts.",
             n_good, n_lrc_bad, n_timeout);
    if (faults == 0 && replies_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== modbus_ascii_reply_receiver.f =====
+incdir+rtl/core
rtl/core/marr_pkg.sv
rtl/core/marr_if.sv
rtl/core/marr_frame.sv
rtl/core/modbus_ascii_reply_receiver.sv
tb/testbench.sv
